// File: rtl/nearest_palette_color_mapper_core_assert.svh
// Assertion macros shared by the mapper modules.
// Each macro samples on clk and is off while arst_n is low.
`ifndef NEAREST_PALETTE_COLOR_MAPPER_CORE_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_MAPPER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define NPCM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define NPCM_ASSERT_NEVER(lbl, expr, msg) \
	`NPCM_ASSERT(lbl, !(expr), msg)
`else
`define NPCM_ASSERT(lbl, prop, msg)
`define NPCM_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// File: rtl/npcm_pkg.sv
package npcm_pkg;

	// Item kinds
	typedef enum logic {
		FUNC_LOAD  = 1'b0,
		FUNC_PIXEL = 1'b1
	} func_t;

	localparam int CHAN_W  = 8;
	localparam int DIST_W  = 18;
	localparam int COUNT_W = 5;
	localparam int SLOT_W  = 4;
	localparam int SLOT_NUM = 16;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [DIST_W-1:0] dist_t;

	typedef struct packed {
		chan_t r;
		chan_t g;
		chan_t b;
	} color_t;

	// Payload of one word as it walks down the cell row
	typedef struct packed {
		func_t  func;
		color_t pix;
		dist_t  best_d;
		color_t best_c;
	} tok_t;

	function automatic logic [2*CHAN_W-1:0] sq_diff(chan_t a, chan_t b);
		chan_t d;
		begin
			d = (a > b) ? (a - b) : (b - a);
			return (2*CHAN_W)'(d) * (2*CHAN_W)'(d);
		end
	endfunction

	// Squared Euclidean RGB distance, at most 195075
	function automatic dist_t color_dist(color_t a, color_t b);
		begin
			return DIST_W'(sq_diff(a.r, b.r)) + DIST_W'(sq_diff(a.g, b.g))
				+ DIST_W'(sq_diff(a.b, b.b));
		end
	endfunction

endpackage

// File: rtl/nearest_palette_color_mapper_core.sv
// The word passes through one register in each cell on its way from start to done.
// Throughput: one word per cycle, loads and pixels freely mixed; busy stays low.
// Loads travel down the row with the pixels, so each pixel sees exactly the loads before it.
// done is a single-cycle strobe; the receiver cannot stall it.
// Reset clears the word valid flags and sets palette_count to 1; palette entries
// stay undefined until loaded.
`include "nearest_palette_color_mapper_core_assert.svh"

module nearest_palette_color_mapper_core #(
	parameter int PALETTE_SIZE = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          func,
	input  logic [npcm_pkg::SLOT_W-1:0]   entry_index,
	input  logic [npcm_pkg::CHAN_W-1:0]   red_in,
	input  logic [npcm_pkg::CHAN_W-1:0]   green_in,
	input  logic [npcm_pkg::CHAN_W-1:0]   blue_in,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [npcm_pkg::COUNT_W-1:0]  cfg_data,
	output logic                          done,
	output logic [npcm_pkg::CHAN_W-1:0]   red_out,
	output logic [npcm_pkg::CHAN_W-1:0]   green_out,
	output logic [npcm_pkg::CHAN_W-1:0]   blue_out,
	output logic [npcm_pkg::SLOT_W-1:0]   chosen_index
);

	localparam int IDXW = $clog2(PALETTE_SIZE);

	logic [npcm_pkg::COUNT_W-1:0] palette_count_q;
	logic [IDXW-1:0]              slot_map [npcm_pkg::SLOT_NUM];
	logic                         chain_valid [PALETTE_SIZE+1];
	npcm_pkg::tok_t               chain_tok   [PALETTE_SIZE+1];
	logic [IDXW-1:0]              chain_slot  [PALETTE_SIZE+1];
	logic [IDXW-1:0]              chain_idx   [PALETTE_SIZE+1];

	// Hold the search count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_count_q <= npcm_pkg::COUNT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			palette_count_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	// Fold a load slot onto the palette size
	for (genvar s = 0; s < npcm_pkg::SLOT_NUM; s++) begin : g_slot
		assign slot_map[s] = IDXW'(s % PALETTE_SIZE);
	end

	// Build the word entering the first cell
	assign chain_valid[0]       = start && !busy;
	assign chain_tok[0].func    = npcm_pkg::func_t'(func);
	assign chain_tok[0].pix     = '{r: red_in, g: green_in, b: blue_in};
	assign chain_tok[0].best_d  = '0;
	assign chain_tok[0].best_c  = '0;
	assign chain_slot[0]        = slot_map[entry_index];
	assign chain_idx[0]         = '0;

	// Row of cells, one palette entry each
	for (genvar i = 0; i < PALETTE_SIZE; i++) begin : g_cell
		npcm_cell #(
			.IDX  (i),
			.IDXW (IDXW)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.count        (palette_count_q),
			.valid_in     (chain_valid[i]),
			.tok_in       (chain_tok[i]),
			.slot_in      (chain_slot[i]),
			.best_idx_in  (chain_idx[i]),
			.valid_out    (chain_valid[i+1]),
			.tok_out      (chain_tok[i+1]),
			.slot_out     (chain_slot[i+1]),
			.best_idx_out (chain_idx[i+1])
		);
	end

	// Drive the result from the last cell
	assign done         = chain_valid[PALETTE_SIZE]
		&& chain_tok[PALETTE_SIZE].func == npcm_pkg::FUNC_PIXEL;
	assign red_out      = chain_tok[PALETTE_SIZE].best_c.r;
	assign green_out    = chain_tok[PALETTE_SIZE].best_c.g;
	assign blue_out     = chain_tok[PALETTE_SIZE].best_c.b;
	assign chosen_index = npcm_pkg::SLOT_W'(chain_idx[PALETTE_SIZE]);

	`NPCM_ASSERT(a_pixel_latency, start && !busy && func == npcm_pkg::FUNC_PIXEL |-> ##PALETTE_SIZE done, "pixel result missing after row latency")
	`NPCM_ASSERT(a_load_silent, start && !busy && func == npcm_pkg::FUNC_LOAD |-> ##PALETTE_SIZE !done, "load word produced a result")
	`NPCM_ASSERT(a_dist_matches, done |-> chain_tok[PALETTE_SIZE].best_d == npcm_pkg::color_dist(chain_tok[PALETTE_SIZE].pix, chain_tok[PALETTE_SIZE].best_c), "best distance does not match chosen color")
	`NPCM_ASSERT_NEVER(a_index_in_range, done && 32'(chain_idx[PALETTE_SIZE]) >= PALETTE_SIZE, "chosen index beyond palette")

endmodule

// File: rtl/npcm_cell.sv
`include "nearest_palette_color_mapper_core_assert.svh"

module npcm_cell #(
	parameter int IDX  = 0,
	parameter int IDXW = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [npcm_pkg::COUNT_W-1:0]  count,
	input  logic                          valid_in,
	input  npcm_pkg::tok_t                tok_in,
	input  logic [IDXW-1:0]               slot_in,
	input  logic [IDXW-1:0]               best_idx_in,
	output logic                          valid_out,
	output npcm_pkg::tok_t                tok_out,
	output logic [IDXW-1:0]               slot_out,
	output logic [IDXW-1:0]               best_idx_out
);

	npcm_pkg::color_t color_q;
	npcm_pkg::dist_t  entry_d;
	logic             in_use;
	logic             take;
	logic             valid_s1;
	npcm_pkg::tok_t   tok_s1;
	logic [IDXW-1:0]  slot_s1;
	logic [IDXW-1:0]  idx_s1;

	// Compare the passing pixel against this cell's entry
	assign entry_d = npcm_pkg::color_dist(tok_in.pix, color_q);
	assign in_use  = (IDX == 0) || (32'(count) > 32'(IDX));
	assign take    = in_use && ((IDX == 0) || (entry_d < tok_in.best_d));

	// Store the entry when a load word for this slot passes
	always_ff @(posedge clk) begin
		if (valid_in && tok_in.func == npcm_pkg::FUNC_LOAD && slot_in == IDXW'(IDX)) begin
			color_q <= tok_in.pix;
		end
	end

	// Advance the word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	// Advance the word, replacing the best match where this entry is in use and strictly closer (cell 0 always takes)
	always_ff @(posedge clk) begin
		slot_s1 <= slot_in;
		if (tok_in.func == npcm_pkg::FUNC_PIXEL && take) begin
			tok_s1 <= '{func: tok_in.func, pix: tok_in.pix, best_d: entry_d, best_c: color_q};
			idx_s1 <= IDXW'(IDX);
		end else begin
			tok_s1 <= tok_in;
			idx_s1 <= best_idx_in;
		end
	end

	assign valid_out    = valid_s1;
	assign tok_out      = tok_s1;
	assign slot_out     = slot_s1;
	assign best_idx_out = idx_s1;

	`NPCM_ASSERT(a_load_stores, valid_in && tok_in.func == npcm_pkg::FUNC_LOAD && slot_in == IDXW'(IDX) |=> color_q == $past(tok_in.pix), "load word did not store its color")
	`NPCM_ASSERT(a_best_never_grows, valid_in && tok_in.func == npcm_pkg::FUNC_PIXEL && IDX != 0 |=> tok_s1.best_d <= $past(tok_in.best_d), "best distance grew along the row")

endmodule
